// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the meter RTL file. They compile to nothing
// when SYNTHESIS is defined. Each one samples on clk and is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge.
`define FRPM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("frpm check failed");

// The antecedent implies the consequent in the same cycle.
`define FRPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frpm implication failed");

// The antecedent implies the consequent in the next cycle.
`define FRPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frpm next-cycle check failed");

`else

`define FRPM_ASSERT(lbl, expr)
`define FRPM_ASSERT_IMPL(lbl, ante, cons)
`define FRPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/frpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame rate meter package
// Widths, constants, register indexes and shared types of the frame rate
// meter and pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package frpm_pkg;

  // Field widths.
  localparam int TICKS_W   = 48;
  localparam int TPS_W     = 40;
  localparam int FPS_W     = 10;
  localparam int FTIME_W   = 32;
  localparam int DELAY_W   = 10;
  localparam int RATE_W    = 24;
  localparam int FRAMES_W  = 32;

  // Shared arithmetic unit: wide enough for elapsed ticks times 256000.
  localparam int ALU_W     = 66;

  // Divider: remainder as wide as the widest divisor, 32-bit quotient.
  localparam int DIVR_W    = 40;
  localparam int DQ_W      = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Target frame time in 1/256 ms is at most 256000.
  localparam int TGT_W     = 18;

  // 256000 = 2^18 - 2^12 - 2^11.
  localparam int MUL_SH0   = 18;
  localparam int MUL_SH1   = 12;
  localparam int MUL_SH2   = 11;

  localparam logic [DQ_W-1:0]   Q8_MS_PER_S  = 32'd256000;
  localparam logic [DQ_W-1:0]   RATE_NUM     = 32'd65536000;
  localparam logic [RATE_W-1:0] MAX_RATE     = 24'hFFFFFF;
  localparam logic [TGT_W-1:0]  DELAY_MIN_Q8 = 18'd512;

  localparam int DEFAULT_SAMPLE_DEPTH = 16;

  // Configuration port.
  localparam int CFG_W     = 64;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TPS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FPS    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_VSYNC  = 2'd3;

  localparam logic [TPS_W-1:0] TPS_RESET   = 40'd1000000000;
  localparam logic [FPS_W-1:0] FPS_RESET   = 10'd60;
  localparam logic             LIMIT_RESET = 1'b1;
  localparam logic             VSYNC_RESET = 1'b0;

  // Input operations.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Shared unit operations.
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  // Configuration register contents.
  typedef struct packed {
    logic [TPS_W-1:0] tps;
    logic [FPS_W-1:0] goal_fps;
    logic             limit_enable;
    logic             vsync_mode;
  } frpm_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/frame_rate_meter_and_pacer.sv =====
// ----------------------------------------------------------------------------
// Frame rate meter and pacer
// An input transaction carries one operation: a finished frame with its tick
// count, or a clear of the statistics. Each input transaction gives exactly
// one output transaction: frame time in 1/256 ms, delay request in whole ms,
// average rate (Q16.8 fps) over a ring of rate samples, and frame count.
// A frame runs through a sequencer around one shared 66-bit adder: two
// product steps, an overflow compare, up to four 32-step restoring divisions
// (frame time, rate, average, target time), a running sum update and a delay
// compare. A clear goes straight to the output step. in_stall is high while
// the sequencer is busy, so a new transaction is taken only in idle. The
// result register holds while out_stall is high and the sequencer then waits
// in its last step. Reset restores the register defaults and clears all
// statistics; the sample ring needs no clearing pass, since per-slot valid
// bits make unwritten slots read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_meter_and_pacer #(
  parameter int SAMPLE_DEPTH = frpm_pkg::DEFAULT_SAMPLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [frpm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [frpm_pkg::CFG_W-1:0]     pwdata,
  output logic      [frpm_pkg::CFG_W-1:0]     prdata,
  output logic                                pready,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           operation,
  input  wire logic [frpm_pkg::TICKS_W-1:0]   frame_ticks,
  // Output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [frpm_pkg::FTIME_W-1:0]   frame_period_q8,
  output logic      [frpm_pkg::DELAY_W-1:0]   wait_ms,
  output logic      [frpm_pkg::RATE_W-1:0]    average_fps_q8,
  output logic      [frpm_pkg::FRAMES_W-1:0]  frame_count
);
  import frpm_pkg::*;

`include "assert_macros.svh"

  localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = RATE_W + $clog2(SAMPLE_DEPTH);
  localparam int DIVS_W = DIVR_W + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL1    = 4'd1;
  localparam logic [3:0] S_MUL2    = 4'd2;
  localparam logic [3:0] S_SATCHK  = 4'd3;
  localparam logic [3:0] S_DIVFT   = 4'd4;
  localparam logic [3:0] S_RATESET = 4'd5;
  localparam logic [3:0] S_DIVRATE = 4'd6;
  localparam logic [3:0] S_SUMADD  = 4'd7;
  localparam logic [3:0] S_SUMSUB  = 4'd8;
  localparam logic [3:0] S_DIVAVG  = 4'd9;
  localparam logic [3:0] S_TGTSET  = 4'd10;
  localparam logic [3:0] S_DIVTGT  = 4'd11;
  localparam logic [3:0] S_DELAY   = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  frpm_cfg_t cfg;

  logic [3:0]            state;
  logic [TICKS_W-1:0]    ticks;
  logic [ALU_W-1:0]      acc;
  logic [DIVR_W-1:0]     rem;
  logic [DQ_W-1:0]       dq;
  logic [DIVR_W-1:0]     divisor;
  logic [STEP_W-1:0]     step;
  logic [FTIME_W-1:0]    ftime;
  logic [RATE_W-1:0]     rate;
  logic [RATE_W-1:0]     old_rate;
  logic [TGT_W-1:0]      target;
  logic [DELAY_W-1:0]    delay_res;

  // Statistics.
  logic [SAMPLE_DEPTH-1:0] slot_valid;
  logic [SLOT_W-1:0]       write_slot;
  logic [SUM_W-1:0]        sample_sum;
  logic [CNT_W-1:0]        nonzero_count;
  logic [RATE_W-1:0]       average_rate;
  logic [FRAMES_W-1:0]     frames_seen;

  // Shared unit connections.
  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_res;
  logic             alu_borrow;

  logic [TPS_W-1:0]  tps_eff;
  logic [FPS_W-1:0]  fps_eff;
  logic [DIVS_W-1:0] shifted;
  logic              q_bit;
  logic [DIVR_W-1:0] rem_step;
  logic [DQ_W-1:0]   dq_step;
  logic              last_step;
  logic              div_busy;
  logic [RATE_W-1:0] ram_rd_data;
  logic [RATE_W-1:0] old_val;
  logic [CNT_W-1:0]  count_upd;
  logic [TGT_W-1:0]  remaining;
  logic              delay_on;

  frpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frpm_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  frpm_ram #(
    .WIDTH (RATE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_samples (
    .clk     (clk),
    .wr_en   (state == S_SUMADD),
    .wr_addr (write_slot),
    .wr_data (rate),
    .rd_en   (state == S_RATESET),
    .rd_addr (write_slot),
    .rd_data (ram_rd_data)
  );

  assign in_stall = (state != S_IDLE);

  // A zero frequency or zero target rate counts as one.
  assign tps_eff = (cfg.tps == '0) ? TPS_W'(1) : cfg.tps;
  assign fps_eff = (cfg.goal_fps == '0) ? FPS_W'(1) : cfg.goal_fps;

  // Restoring division step: shift in the next dividend bit, try subtract.
  assign shifted   = {rem, dq[DQ_W-1]};
  assign q_bit     = ~alu_borrow;
  assign rem_step  = q_bit ? alu_res[DIVR_W-1:0] : shifted[DIVR_W-1:0];
  assign dq_step   = {dq[DQ_W-2:0], q_bit};
  assign last_step = (step == STEP_W'(DIV_STEPS - 1));
  assign div_busy  = (state == S_DIVFT) || (state == S_DIVRATE) ||
                     (state == S_DIVAVG) || (state == S_DIVTGT);

  // Sample being replaced; a slot never written reads as zero.
  assign old_val   = slot_valid[write_slot] ? ram_rd_data : '0;
  assign count_upd = nonzero_count + CNT_W'(rate != '0) - CNT_W'(old_val != '0);

  // Delay request from the target minus frame time compare.
  assign remaining = alu_res[TGT_W-1:0];
  assign delay_on  = ~cfg.vsync_mode & cfg.limit_enable & ~alu_borrow
                     & (remaining > DELAY_MIN_Q8);

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_MUL1: begin
        alu_a = acc;
        alu_b = ALU_W'(ticks) << MUL_SH1;
      end
      S_MUL2: begin
        alu_a = acc;
        alu_b = ALU_W'(ticks) << MUL_SH2;
      end
      S_SATCHK: begin
        alu_a = ALU_W'(acc[ALU_W-1:DQ_W]);
        alu_b = ALU_W'(tps_eff);
      end
      S_DIVFT, S_DIVRATE, S_DIVAVG, S_DIVTGT: begin
        alu_a = ALU_W'(shifted);
        alu_b = ALU_W'(divisor);
      end
      S_SUMADD: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(sample_sum);
        alu_b  = ALU_W'(rate);
      end
      S_SUMSUB: begin
        alu_a = acc;
        alu_b = ALU_W'(old_rate);
      end
      S_DELAY: begin
        alu_a = ALU_W'(target);
        alu_b = ALU_W'(ftime);
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      write_slot    <= '0;
      sample_sum    <= '0;
      nonzero_count <= '0;
      average_rate  <= '0;
      frames_seen   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The result register empties when taken, unless it is reloaded below.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == OP_CLEAR) begin
              slot_valid    <= '0;
              write_slot    <= '0;
              sample_sum    <= '0;
              nonzero_count <= '0;
              average_rate  <= '0;
              frames_seen   <= '0;
              ftime         <= '0;
              delay_res     <= '0;
              state         <= S_OUT;
            end else begin
              ticks <= frame_ticks;
              acc   <= ALU_W'(frame_ticks) << MUL_SH0;
              state <= S_MUL1;
            end
          end
        end
        // Ticks times 256000 by shift and subtract.
        S_MUL1: begin
          acc   <= alu_res;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= alu_res;
          state <= S_SATCHK;
        end
        // The quotient fits in 32 bits only if the upper dividend is below the divisor.
        S_SATCHK: begin
          if (!alu_borrow) begin
            ftime <= '1;
            state <= S_RATESET;
          end else begin
            rem     <= DIVR_W'(acc[ALU_W-1:DQ_W]);
            dq      <= acc[DQ_W-1:0];
            divisor <= tps_eff;
            step    <= '0;
            state   <= S_DIVFT;
          end
        end
        S_DIVFT: begin
          rem  <= rem_step;
          dq   <= dq_step;
          step <= step + 1'b1;
          if (last_step) begin
            ftime <= dq_step;
            state <= S_RATESET;
          end
        end
        // A zero frame time leaves the ring and average alone.
        S_RATESET: begin
          if (ftime == '0) begin
            state <= S_TGTSET;
          end else begin
            rem     <= '0;
            dq      <= RATE_NUM;
            divisor <= DIVR_W'(ftime);
            step    <= '0;
            state   <= S_DIVRATE;
          end
        end
        S_DIVRATE: begin
          rem  <= rem_step;
          dq   <= dq_step;
          step <= step + 1'b1;
          if (last_step) begin
            rate  <= (dq_step[DQ_W-1:RATE_W] != '0) ? MAX_RATE : dq_step[RATE_W-1:0];
            state <= S_SUMADD;
          end
        end
        // Store the new sample and advance the ring.
        S_SUMADD: begin
          acc                    <= alu_res;
          old_rate               <= old_val;
          nonzero_count          <= count_upd;
          slot_valid[write_slot] <= 1'b1;
          if (write_slot == SLOT_W'(SAMPLE_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
          state <= S_SUMSUB;
        end
        S_SUMSUB: begin
          sample_sum <= alu_res[SUM_W-1:0];
          if (nonzero_count != '0) begin
            rem     <= '0;
            dq      <= DQ_W'(alu_res[SUM_W-1:0]);
            divisor <= DIVR_W'(nonzero_count);
            step    <= '0;
            state   <= S_DIVAVG;
          end else begin
            state <= S_TGTSET;
          end
        end
        S_DIVAVG: begin
          rem  <= rem_step;
          dq   <= dq_step;
          step <= step + 1'b1;
          if (last_step) begin
            average_rate <= dq_step[RATE_W-1:0];
            state        <= S_TGTSET;
          end
        end
        // Target frame time 256000 / target rate.
        S_TGTSET: begin
          rem     <= '0;
          dq      <= Q8_MS_PER_S;
          divisor <= DIVR_W'(fps_eff);
          step    <= '0;
          state   <= S_DIVTGT;
        end
        S_DIVTGT: begin
          rem  <= rem_step;
          dq   <= dq_step;
          step <= step + 1'b1;
          if (last_step) begin
            target <= dq_step[TGT_W-1:0];
            state  <= S_DELAY;
          end
        end
        // Remaining minus 1 ms, in whole ms.
        S_DELAY: begin
          delay_res   <= delay_on ? (remaining[TGT_W-1:TGT_W-DELAY_W] - 1'b1) : '0;
          frames_seen <= frames_seen + 1'b1;
          state       <= S_OUT;
        end
        // Load the result register once it is free.
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            frame_period_q8 <= ftime;
            wait_ms         <= delay_res;
            average_fps_q8  <= average_rate;
            frame_count     <= frames_seen;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Design checks.
  `FRPM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FRPM_ASSERT(a_count_bound, nonzero_count <= CNT_W'(SAMPLE_DEPTH))
  `FRPM_ASSERT_IMPL(a_rem_below_divisor, div_busy, rem < divisor)
  `FRPM_ASSERT_IMPL(a_delay_gated, out_valid && wait_ms != '0, !cfg.vsync_mode && cfg.limit_enable)

endmodule

`default_nettype wire

// ===== rtl/core/frpm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module frpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frpm_alu.sv =====
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One wide adder used for every product step, compare, division step and
// running sum update of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module frpm_alu (
  input  wire logic                     op,
  input  wire logic [frpm_pkg::ALU_W-1:0] a,
  input  wire logic [frpm_pkg::ALU_W-1:0] b,
  output logic      [frpm_pkg::ALU_W-1:0] res,
  output logic                          borrow
);
  import frpm_pkg::*;

  localparam int ALUX_W = ALU_W + 1;

  logic             is_sub;
  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   sum_ext;

  // Subtraction is an add of the inverted operand with a carry in.
  assign is_sub  = (op == ALU_SUB);
  assign b_eff   = is_sub ? ~b : b;
  assign sum_ext = {1'b0, a} + {1'b0, b_eff} + ALUX_W'(is_sub);
  assign res     = sum_ext[ALU_W-1:0];
  assign borrow  = is_sub & ~sum_ext[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/core/frpm_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file: tick frequency, target rate, limit enable and
// vsync mode, at 8-byte spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module frpm_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [frpm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [frpm_pkg::CFG_W-1:0]     pwdata,
  output logic      [frpm_pkg::CFG_W-1:0]     prdata,
  output logic                                pready,
  output frpm_pkg::frpm_cfg_t                 cfg
);
  import frpm_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps          <= TPS_RESET;
      cfg.goal_fps     <= FPS_RESET;
      cfg.limit_enable <= LIMIT_RESET;
      cfg.vsync_mode   <= VSYNC_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TPS:   cfg.tps          <= pwdata[TPS_W-1:0];
        REG_FPS:   cfg.goal_fps     <= pwdata[FPS_W-1:0];
        REG_LIMIT: cfg.limit_enable <= pwdata[0];
        REG_VSYNC: cfg.vsync_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      REG_TPS:   prdata = CFG_W'(cfg.tps);
      REG_FPS:   prdata = CFG_W'(cfg.goal_fps);
      REG_LIMIT: prdata = CFG_W'(cfg.limit_enable);
      REG_VSYNC: prdata = CFG_W'(cfg.vsync_mode);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== test/frame_rate_meter_and_pacer_tb.sv =====
// ----------------------------------------------------------------------------
// Frame rate meter and pacer testbench
// Sends frame and clear transactions through the block under a series of
// register settings and handshake idling patterns. A behavioral model of the
// meter predicts the results that no directed row states, and each output
// transaction is compared field by field with the oldest result still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_meter_and_pacer_tb;
  import frpm_pkg::*;

  localparam int RING_DEPTH    = DEFAULT_SAMPLE_DEPTH;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int RESET_CYCLES  = 8;
  localparam int N_DIRECTED    = 20;
  localparam int N_PHASES      = 8;
  localparam int CLEAR_PCT     = 6;

  typedef struct packed {
    logic [FTIME_W-1:0]  ftime;
    logic [DELAY_W-1:0]  delay;
    logic [RATE_W-1:0]   avg_rate;
    logic [FRAMES_W-1:0] frames;
  } frame_result_t;

  typedef struct packed {
    logic               op;
    logic [TICKS_W-1:0] ticks;
    logic               known;
    frame_result_t      want;
  } directed_row_t;

  typedef struct packed {
    logic [TPS_W-1:0] tps;
    logic [FPS_W-1:0] fps;
    logic             limit_en;
    logic             vsync_en;
    logic [6:0]       gap_pct;
    logic [6:0]       stall_pct;
    logic [9:0]       items;
  } phase_t;

  // Directed transactions run with the register defaults after reset.
  directed_row_t directed_rows [N_DIRECTED] = '{
    // Zero frame time right after reset: empty ring, delay for the full target.
    '{OP_FRAME, 48'd0, 1'b1, '{32'd0, 10'd15, 24'd0, 32'd1}},
    // Clear with every tick bit set; the ticks are ignored.
    '{OP_CLEAR, 48'hFFFF_FFFF_FFFF, 1'b1, '{32'd0, 10'd0, 24'd0, 32'd0}},
    '{OP_FRAME, 48'd16666667, 1'b0, '0},
    // Largest tick count saturates the frame time.
    '{OP_FRAME, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{OP_FRAME, 48'd1000000, 1'b0, '0},
    // Frame times of 1 and 3 saturate the rate, 4 does not.
    '{OP_FRAME, 48'd4000, 1'b0, '0},
    '{OP_FRAME, 48'd12000, 1'b0, '0},
    '{OP_FRAME, 48'd16000, 1'b0, '0},
    '{OP_FRAME, 48'd3906, 1'b0, '0},
    // Rate of exactly one, then a rate that floors to zero.
    '{OP_FRAME, 48'd256000000000, 1'b0, '0},
    '{OP_FRAME, 48'd257000000000, 1'b0, '0},
    // Remaining time of 512 and 513 around the delay threshold.
    '{OP_FRAME, 48'd14664063, 1'b0, '0},
    '{OP_FRAME, 48'd14660157, 1'b0, '0},
    // Whole seconds just below and just above the frame time overflow.
    '{OP_FRAME, 48'd16777000000000, 1'b0, '0},
    '{OP_FRAME, 48'd16778000000000, 1'b0, '0},
    '{OP_CLEAR, 48'd0, 1'b1, '{32'd0, 10'd0, 24'd0, 32'd0}},
    // Only a zero-rate sample after clear: the average stays at zero.
    '{OP_FRAME, 48'd257000000000, 1'b1, '{32'd65792000, 10'd0, 24'd0, 32'd1}},
    '{OP_FRAME, 48'd1, 1'b1, '{32'd0, 10'd15, 24'd0, 32'd2}},
    '{OP_FRAME, 48'd1000000000, 1'b1, '{32'd256000, 10'd0, 24'd256, 32'd3}},
    '{OP_FRAME, 48'h8000_0000_0000, 1'b0, '0}
  };

  // Register settings and idling pattern of each random phase.
  phase_t phase_plan [N_PHASES] = '{
    '{40'd1000000000, 10'd60, 1'b1, 1'b0, 7'd0, 7'd0, 10'd70},
    '{40'd1000, 10'd144, 1'b1, 1'b0, 7'd73, 7'd0, 10'd70},
    '{40'd0, 10'd0, 1'b1, 1'b0, 7'd0, 7'd73, 10'd60},
    '{40'hFF_FFFF_FFFF, 10'd1000, 1'b1, 1'b0, 7'd32, 7'd32, 10'd70},
    '{40'd48000, 10'd1, 1'b1, 1'b1, 7'd0, 7'd0, 10'd60},
    '{40'd1, 10'd30, 1'b0, 1'b0, 7'd73, 7'd0, 10'd60},
    '{40'd1000000000, 10'd240, 1'b0, 1'b1, 7'd0, 7'd73, 10'd70},
    '{40'd25000000, 10'd1023, 1'b1, 1'b0, 7'd32, 7'd32, 10'd70}
  };

  logic                clk;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [CFG_W-1:0]    pwdata    = '0;
  logic [CFG_W-1:0]    prdata;
  logic                pready;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic                operation = OP_FRAME;
  logic [TICKS_W-1:0]  frame_ticks = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FTIME_W-1:0]  frame_period_q8;
  logic [DELAY_W-1:0]  wait_ms;
  logic [RATE_W-1:0]   average_fps_q8;
  logic [FRAMES_W-1:0] frame_count;

  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int          mismatches = 0;

  frame_result_t pending_results [$];

  // Model copy of the registers and the statistics.
  logic [TPS_W-1:0]    tick_rate;
  logic [FPS_W-1:0]    fps_goal;
  logic                limit_on;
  logic                vsync_on;
  logic [RATE_W-1:0]   rate_ring [RING_DEPTH];
  int unsigned         ring_pos;
  logic [63:0]         rate_total;
  int unsigned         live_samples;
  logic [RATE_W-1:0]   mean_rate;
  logic [FRAMES_W-1:0] frames_done;

  frame_rate_meter_and_pacer dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .frame_ticks     (frame_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_period_q8 (frame_period_q8),
    .wait_ms         (wait_ms),
    .average_fps_q8  (average_fps_q8),
    .frame_count     (frame_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Zero every statistic of the model; the registers keep their values.
  function automatic void clear_meter_stats();
    foreach (rate_ring[i]) rate_ring[i] = '0;
    ring_pos     = 0;
    rate_total   = '0;
    live_samples = 0;
    mean_rate    = '0;
    frames_done  = '0;
  endfunction

  // Frame time in 1/256 ms from a tick count, floored and saturated.
  function automatic logic [FTIME_W-1:0] ticks_to_q8ms(input logic [TICKS_W-1:0] ticks);
    logic [63:0] freq;
    logic [63:0] whole;
    logic [63:0] part;
    logic [63:0] total;
    freq  = (tick_rate == 0) ? 64'd1 : 64'(tick_rate);
    whole = 64'(ticks) / freq;
    part  = 64'(ticks) % freq;
    if (whole > 64'(32'hFFFF_FFFF / Q8_MS_PER_S)) return '1;
    total = whole * 64'(Q8_MS_PER_S) + (part * 64'(Q8_MS_PER_S)) / freq;
    return (total > 64'hFFFF_FFFF) ? '1 : total[FTIME_W-1:0];
  endfunction

  // Advance the model by one transaction and return its result.
  function automatic frame_result_t meter_step(input logic op,
                                               input logic [TICKS_W-1:0] ticks);
    frame_result_t res;
    logic [31:0]   rate;
    logic [31:0]   target;
    res = '0;
    if (op == OP_CLEAR) begin
      clear_meter_stats();
      return res;
    end
    res.ftime = ticks_to_q8ms(ticks);

    // A nonzero frame time replaces the oldest sample in the ring.
    if (res.ftime != 0) begin
      rate = RATE_NUM / res.ftime;
      if (rate > 32'(MAX_RATE)) rate = 32'(MAX_RATE);
      rate_total = rate_total - 64'(rate_ring[ring_pos]) + 64'(rate);
      if (rate_ring[ring_pos] != 0) live_samples--;
      if (rate != 0) live_samples++;
      rate_ring[ring_pos] = rate[RATE_W-1:0];
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      if (live_samples != 0) mean_rate = RATE_W'(rate_total / 64'(live_samples));
    end

    // Delay request when the frame finished well before the target time.
    target = Q8_MS_PER_S / ((fps_goal == 0) ? 32'd1 : 32'(fps_goal));
    if (!vsync_on && limit_on && res.ftime < target &&
        target - res.ftime > 32'(DELAY_MIN_Q8))
      res.delay = DELAY_W'((target - res.ftime - 32'd256) >> 8);

    frames_done++;
    res.avg_rate = mean_rate;
    res.frames   = frames_done;
    return res;
  endfunction

  // Random tick count, mostly near the target frame time.
  function automatic logic [TICKS_W-1:0] pick_ticks();
    logic [63:0] freq;
    logic [63:0] target;
    logic [63:0] span;
    int unsigned shape;
    freq   = (tick_rate == 0) ? 64'd1 : 64'(tick_rate);
    target = 64'(Q8_MS_PER_S) / ((fps_goal == 0) ? 64'd1 : 64'(fps_goal));
    shape  = $urandom_range(99);
    if (shape < 55) begin
      span = 64'($urandom_range(0, 32'(2 * target + 1024)));
      return TICKS_W'(freq * span / 64'(Q8_MS_PER_S) + 64'($urandom_range(0, 3)));
    end else if (shape < 72) begin
      return TICKS_W'({$urandom(), $urandom()});
    end else if (shape < 84) begin
      // Frame times of 0 to 5 units, around zero frame time and rate saturation.
      span = 64'($urandom_range(0, 5));
      return TICKS_W'(freq * span / 64'(Q8_MS_PER_S) + 64'($urandom_range(0, 2)));
    end else if (shape < 94) begin
      // Frames around 256 s, where the rate falls from one to zero.
      span = 64'($urandom_range(250, 262));
      return TICKS_W'(freq * span + 64'($urandom_range(0, 999)));
    end
    return ($urandom_range(1) != 0) ? '1 : '0;
  endfunction

  // Hold the first state of the model in step with reset.
  task automatic reset_meter_model();
    tick_rate = TPS_RESET;
    fps_goal  = FPS_RESET;
    limit_on  = LIMIT_RESET;
    vsync_on  = VSYNC_RESET;
    clear_meter_stats();
  endtask

  // One register write: setup cycle, access cycle, then an idle cycle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TPS:   tick_rate = value[TPS_W-1:0];
      REG_FPS:   fps_goal  = value[FPS_W-1:0];
      REG_LIMIT: limit_on  = value[0];
      REG_VSYNC: vsync_on  = value[0];
      default: ;
    endcase
  endtask

  // Send one input transaction after a random gap, then queue its result.
  task automatic send_item(input logic op, input logic [TICKS_W-1:0] ticks,
                           input logic known, input frame_result_t want);
    frame_result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    frame_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = meter_step(op, ticks);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Stop sending and wait until every queued result has been received.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field_name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
      mismatches++;
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each output transaction with the oldest queued result.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output transaction: frame_period_q8 %0d, frame_count %0d",
               frame_period_q8, frame_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_period_q8", 64'(want.ftime), 64'(frame_period_q8));
        check_field("wait_ms", 64'(want.delay), 64'(wait_ms));
        check_field("average_fps_q8", 64'(want.avg_rate), 64'(average_fps_q8));
        check_field("frame_count", 64'(want.frames), 64'(frame_count));
      end
    end
  end

  // Main sequence: reset, directed transactions, then the random phases.
  initial begin : stimulus
    logic op;
    int   hold_at;
    reset_meter_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].ticks,
                directed_rows[i].known, directed_rows[i].want);
    end

    foreach (phase_plan[p]) begin
      wait_drained();
      write_reg(REG_TPS, CFG_W'(phase_plan[p].tps));
      write_reg(REG_FPS, CFG_W'(phase_plan[p].fps));
      write_reg(REG_LIMIT, CFG_W'(phase_plan[p].limit_en));
      write_reg(REG_VSYNC, CFG_W'(phase_plan[p].vsync_en));
      gap_pct   = phase_plan[p].gap_pct;
      stall_pct = phase_plan[p].stall_pct;
      // Somewhere in each phase the sender pauses until the block is empty.
      hold_at = $urandom_range(1, phase_plan[p].items - 1);
      for (int n = 0; n < phase_plan[p].items; n++) begin
        if (n == hold_at) wait_drained();
        op = ($urandom_range(99) < CLEAR_PCT) ? OP_CLEAR : OP_FRAME;
        send_item(op, pick_ticks(), 1'b0, '0);
      end
    end

    wait_drained();
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
